// File: rtl/chunk_lru_cache_lookup_unit_macros.svh
`ifndef CHUNK_LRU_CACHE_LOOKUP_UNIT_MACROS_SVH
`define CHUNK_LRU_CACHE_LOOKUP_UNIT_MACROS_SVH

// concurrent check on the rising clock, off while reset is high
`define CLCL_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check sampled in the cycle after the trigger
`define CLCL_CHECK_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) trig |=> prop) else $error(msg);

`endif

// File: rtl/clcl_pkg.sv
`default_nettype none

package clcl_pkg;

   localparam int ROW_W      = 40;
   localparam int NEED_W     = 31;
   localparam int TOTAL_W    = 41;
   localparam int FIELD_W    = 10;
   localparam int SLOT_OUT_W = 4;
   localparam int COUNT_W    = 48;
   localparam int STAMP_W    = 64;
   localparam int BIT_CNT_W  = $clog2(ROW_W);

   localparam int CHUNK_ROWS_DEFAULT = 1000;
   localparam int SLOTS_DEFAULT      = 12;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [NEED_W-1:0] rows_needed;
   } clcl_req_type;

   typedef struct packed {
      logic                  status;
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic [ROW_W-1:0]      chunk_base_row;
      logic [FIELD_W-1:0]    chunk_rows;
      logic [FIELD_W-1:0]    row_in_chunk;
      logic [FIELD_W-1:0]    rows_granted;
      logic [COUNT_W-1:0]    hit_total;
      logic [COUNT_W-1:0]    miss_total;
      logic [SLOT_OUT_W-1:0] slots_in_use;
   } clcl_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_QUOT,
      ST_REM,
      ST_BASE,
      ST_CLAMP,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } clcl_state_type;

endpackage

`default_nettype wire

// File: rtl/chunk_lru_cache_lookup_unit.sv
// channel   direction   handshake             beat
// req       in          req_valid/req_stall   clcl_req_type (row, rows_needed)
// rsp       out         rsp_valid/rsp_stall   clcl_rsp_type
// csr       in          csr_wr_en             csr_wr_data (total_rows)
//
// served beat: accept, 2 fold steps, quotient, remainder, base, clamp, SLOTS scan steps,
//    update, then done
// rejected beat: accept then done; no divide and no scan
// reset is synchronous, active high; slot table valid bits clear at once, no sweep
// a held rsp beat does not block the next req; the unit waits in done only to load rsp
`default_nettype none

`include "chunk_lru_cache_lookup_unit_macros.svh"

module chunk_lru_cache_lookup_unit
   import clcl_pkg::*;
#(
   parameter int CHUNK_ROWS = CHUNK_ROWS_DEFAULT,
   parameter int SLOTS      = SLOTS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire clcl_req_type       req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output clcl_rsp_type            rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [TOTAL_W-1:0] csr_wr_data
);

   localparam int REM_W  = (CHUNK_ROWS > 1) ? $clog2(CHUNK_ROWS) : 1;
   localparam int LEN_W  = $clog2(CHUNK_ROWS + 1);
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int USE_W  = $clog2(SLOTS + 1);

   localparam int FOLD_W     = 20;
   localparam int FOLD_STEPS = 2;
   localparam int RED_W      = 21;
   localparam int FPROD_W    = ROW_W - FOLD_W + REM_W;
   localparam int RED_SHIFT  = RED_W + REM_W;
   localparam int RECIP_W    = RED_W + 2;
   localparam int RPROD_W    = RED_W + RECIP_W;
   localparam int QUOT_W     = RPROD_W - RED_SHIFT;

   localparam logic [REM_W-1:0]     FOLD_MOD   = REM_W'((64'd1 << FOLD_W) % CHUNK_ROWS);
   localparam logic [RECIP_W-1:0]   RECIP      =
      RECIP_W'(((64'd1 << RED_SHIFT) + 64'(CHUNK_ROWS) - 64'd1) / 64'(CHUNK_ROWS));
   localparam logic [RED_W-1:0]     CHUNK_RED  = RED_W'(CHUNK_ROWS);
   localparam logic [TOTAL_W-1:0]   CHUNK_TOT  = TOTAL_W'(CHUNK_ROWS);
   localparam logic [LEN_W-1:0]     CHUNK_LEN  = LEN_W'(CHUNK_ROWS);
   localparam logic [SLOT_W-1:0]    SLOT_LAST  = SLOT_W'(SLOTS - 1);
   localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(FOLD_STEPS - 1);

   clcl_state_type state_ff, state_in;

   logic [TOTAL_W-1:0]   total_rows_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [NEED_W-1:0]    need_ff;
   logic [ROW_W-1:0]     div_ff;
   logic [QUOT_W-1:0]    quot_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [BIT_CNT_W-1:0] bit_ff;
   logic                 reject_ff;
   logic [ROW_W-1:0]     base_ff;
   logic [LEN_W-1:0]     len_ff;

   logic [SLOT_W-1:0]    idx_ff;
   logic                 hit_found_ff;
   logic [SLOT_W-1:0]    hit_idx_ff;
   logic [LEN_W-1:0]     hit_rows_ff;
   logic                 free_found_ff;
   logic [SLOT_W-1:0]    free_idx_ff;
   logic [SLOT_W-1:0]    victim_idx_ff;
   logic [STAMP_W-1:0]   victim_stamp_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [LEN_W-1:0]     avail_ff;

   logic [SLOTS-1:0]     slot_valid_ff;
   logic [ROW_W-1:0]     slot_base_ff  [SLOTS];
   logic [LEN_W-1:0]     slot_rows_ff  [SLOTS];
   logic [STAMP_W-1:0]   slot_stamp_ff [SLOTS];

   logic [STAMP_W-1:0]   use_clock_ff;
   logic [COUNT_W-1:0]   hit_count_ff;
   logic [COUNT_W-1:0]   miss_count_ff;
   logic [USE_W-1:0]     in_use_ff;

   logic                 rsp_valid_ff;
   clcl_rsp_type         rsp_data_ff;

   logic                 req_take;
   logic                 req_reject;
   logic                 rsp_load;
   logic [FPROD_W-1:0]   fold_prod;
   logic [ROW_W-1:0]     fold_in;
   logic [RPROD_W-1:0]   red_prod;
   logic [RED_W-1:0]     rem_full;
   logic [TOTAL_W-1:0]   tail_rows;
   logic [LEN_W-1:0]     len_in;
   logic [SLOT_W-1:0]    upd_slot;
   logic [LEN_W-1:0]     upd_rows;
   logic [LEN_W-1:0]     rem_ext;
   logic [LEN_W-1:0]     avail_in;
   logic [STAMP_W-1:0]   stamp_in;
   logic [LEN_W-1:0]     grant;
   clcl_rsp_type         rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_stall  = (state_ff != ST_IDLE);
      req_take   = 1'b0;
      rsp_load   = 1'b0;
      req_reject = ({1'b0, req_data.row} >= total_rows_ff) || (req_data.rows_needed == '0);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_take = 1'b1;
               state_in = req_reject ? ST_DONE : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (bit_ff == BIT_LAST) begin
               state_in = ST_QUOT;
            end
         end
         ST_QUOT: begin
            state_in = ST_REM;
         end
         ST_REM: begin
            state_in = ST_BASE;
         end
         ST_BASE: begin
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (idx_ff == SLOT_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fold the row by 2^20 mod chunk twice, then reciprocal quotient and remainder
   assign fold_prod = FPROD_W'(div_ff[ROW_W-1:FOLD_W]) * FPROD_W'(FOLD_MOD);
   assign fold_in   = ROW_W'(fold_prod) + ROW_W'(div_ff[FOLD_W-1:0]);
   assign red_prod  = RPROD_W'(div_ff[RED_W-1:0]) * RPROD_W'(RECIP);
   assign rem_full  = div_ff[RED_W-1:0] - (RED_W'(quot_ff) * CHUNK_RED);

   assign tail_rows = total_rows_ff - {1'b0, base_ff};
   assign len_in    = (tail_rows < CHUNK_TOT) ? LEN_W'(tail_rows) : CHUNK_LEN;

   assign upd_slot = hit_found_ff  ? hit_idx_ff  :
                     free_found_ff ? free_idx_ff : victim_idx_ff;
   assign upd_rows = hit_found_ff ? hit_rows_ff : len_ff;
   assign rem_ext  = LEN_W'(rem_ff);
   assign avail_in = (upd_rows > rem_ext) ? (upd_rows - rem_ext) : '0;
   assign stamp_in = use_clock_ff + 1'b1;
   assign grant    = (NEED_W'(avail_ff) < need_ff) ? avail_ff : LEN_W'(need_ff);

   always_ff @(posedge clock) begin
      if (req_take) begin
         row_ff  <= req_data.row;
         need_ff <= req_data.rows_needed;
         div_ff  <= req_data.row;
      end else if (state_ff == ST_DIVIDE) begin
         div_ff <= fold_in;
      end
      if (state_ff == ST_QUOT) begin
         quot_ff <= red_prod[RPROD_W-1:RED_SHIFT];
      end
      if (state_ff == ST_REM) begin
         rem_ff <= rem_full[REM_W-1:0];
      end
      if (state_ff == ST_BASE) begin
         base_ff <= row_ff - ROW_W'(rem_ff);
      end
      if (state_ff == ST_CLAMP) begin
         len_ff <= len_in;
      end
      if (state_ff == ST_SCAN) begin
         if (slot_valid_ff[idx_ff] && (slot_base_ff[idx_ff] == base_ff) && !hit_found_ff) begin
            hit_idx_ff  <= idx_ff;
            hit_rows_ff <= slot_rows_ff[idx_ff];
         end
         if (!slot_valid_ff[idx_ff] && !free_found_ff) begin
            free_idx_ff <= idx_ff;
         end
         // oldest stamp, lowest index on ties; used only when every slot is valid
         if ((idx_ff == '0) || (slot_stamp_ff[idx_ff] < victim_stamp_ff)) begin
            victim_idx_ff   <= idx_ff;
            victim_stamp_ff <= slot_stamp_ff[idx_ff];
         end
      end
      if (state_ff == ST_UPDATE) begin
         slot_ff  <= upd_slot;
         avail_ff <= avail_in;
         slot_stamp_ff[upd_slot] <= stamp_in;
         if (!hit_found_ff) begin
            slot_base_ff[upd_slot] <= base_ff;
            slot_rows_ff[upd_slot] <= len_ff;
         end
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_rows_ff <= '0;
         bit_ff        <= '0;
         reject_ff     <= 1'b0;
         idx_ff        <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         use_clock_ff  <= '0;
         hit_count_ff  <= '0;
         miss_count_ff <= '0;
         in_use_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            total_rows_ff <= csr_wr_data;
         end
         if (req_take) begin
            bit_ff    <= '0;
            reject_ff <= req_reject;
         end else if (state_ff == ST_DIVIDE) begin
            bit_ff <= bit_ff + 1'b1;
         end
         if (state_ff == ST_CLAMP) begin
            idx_ff        <= '0;
            hit_found_ff  <= 1'b0;
            free_found_ff <= 1'b0;
         end
         if (state_ff == ST_SCAN) begin
            idx_ff <= idx_ff + 1'b1;
            if (slot_valid_ff[idx_ff] && (slot_base_ff[idx_ff] == base_ff)) begin
               hit_found_ff <= 1'b1;
            end
            if (!slot_valid_ff[idx_ff]) begin
               free_found_ff <= 1'b1;
            end
         end
         if (state_ff == ST_UPDATE) begin
            use_clock_ff <= stamp_in;
            if (hit_found_ff) begin
               if (hit_count_ff != '1) begin
                  hit_count_ff <= hit_count_ff + 1'b1;
               end
            end else begin
               if (miss_count_ff != '1) begin
                  miss_count_ff <= miss_count_ff + 1'b1;
               end
               slot_valid_ff[upd_slot] <= 1'b1;
               if (free_found_ff) begin
                  in_use_ff <= in_use_ff + 1'b1;
               end
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_data_in                = '0;
      rsp_data_in.status         = reject_ff;
      rsp_data_in.hit_total      = hit_count_ff;
      rsp_data_in.miss_total     = miss_count_ff;
      rsp_data_in.slots_in_use   = SLOT_OUT_W'(in_use_ff);
      if (!reject_ff) begin
         rsp_data_in.hit            = hit_found_ff;
         rsp_data_in.slot           = SLOT_OUT_W'(slot_ff);
         rsp_data_in.chunk_base_row = base_ff;
         rsp_data_in.chunk_rows     = FIELD_W'(upd_rows);
         rsp_data_in.row_in_chunk   = FIELD_W'(rem_ff);
         rsp_data_in.rows_granted   = FIELD_W'(grant);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CLCL_CHECK(a_use_count, (in_use_ff == USE_W'($countones(slot_valid_ff))), "slot use count off")
   `CLCL_CHECK(a_scan_range, (state_ff != ST_SCAN) || (idx_ff <= SLOT_LAST), "scan past table")
   `CLCL_CHECK_NEXT(a_slot_set, (state_ff == ST_UPDATE), slot_valid_ff[slot_ff], "slot not valid")
   `CLCL_CHECK_NEXT(a_hit_mono, 1'b1, (hit_count_ff >= $past(hit_count_ff)), "hit count fell")
   `CLCL_CHECK(a_rsp_src, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "rsp beat not from done")

endmodule

`default_nettype wire
